// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SALC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: invariant violated");

// Same-cycle implication outside reset.
`define SALC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication violated");

// Next-cycle implication outside reset.
`define SALC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication violated");

`endif

// ===== rtl/salc_pkg.sv =====
// Shared types, constants and helpers of the LRU cache simulator core.
`default_nettype none
package salc_pkg;

  // Default geometry limits
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int TAG_W            = 64;
  localparam int CNT_W            = 32;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 6;

  // Access kinds
  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2,
    OP_FETCH  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS_USED  = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] address;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       hits;
    logic             missed;
    logic             evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_item_t;

  // Outcome of one lookup on a set
  typedef struct packed {
    logic hit;
    logic evict;
  } acc_res_t;

  // Saturating add of a small increment
  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, logic [1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/set_assoc_lru_cache_sim_core.sv =====
// Top level of the tag-only set-associative LRU cache simulator.
//
// Usage:
//   in channel  (in_valid/in_ready/in_data): one access, op and byte address.
//   out channel (out_valid/out_ready/out_data): one result item per access,
//     with this access's hits, miss and eviction plus saturating totals.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): set_bits,
//     ways_used, block_bits; write only while no access is in flight.
// Timing: an accepted item reads its set row from the set RAM; once the
//   output register is free, the core updates the row, writes it back and
//   loads the output register, the read-modify-write of the
//   one-port-per-direction set RAM; in_ready returns in the cycle after that.
// A modify is handled in the same single pass (its second access is a hit).
// Reset: all lines invalid, ranks equal to way numbers, totals and config
//   back to defaults; tracked per set by flip-flops, no clearing pass.
// Stall: a finished result waits in the output register; the core holds
//   the next item in its update cycle until that register frees up.
`default_nettype none
module set_assoc_lru_cache_sim_core
  import salc_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int SET_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int DEPTH  = 1 << MAX_SET_BITS;
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_W  = 1 + TAG_W + RANK_W;
  localparam int ROW_W  = MAX_WAYS * WAY_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t            state;
  logic [2:0]        set_bits;
  logic [3:0]        ways_used;
  logic [5:0]        block_bits;
  logic [CNT_W-1:0]  hit_total, miss_total, eviction_total;
  logic [DEPTH-1:0]  row_written;

  op_t               op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic              fresh_q;

  logic              in_acc, commit, is_fetch, wr_en;
  logic [2:0]        sb_eff;
  logic [63:0]       addr_sh;
  logic [SET_W-1:0]  set_idx;
  logic [6:0]        tag_sh;
  logic [TAG_W-1:0]  tag_calc;
  logic [ROW_W-1:0]  row_rd, row_wr;
  acc_res_t          res;
  logic [1:0]        hits_now;
  out_item_t         out_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign commit    = (state == ST_LOOK) && (!out_valid || out_ready);
  assign is_fetch  = (op_q == OP_FETCH);
  assign wr_en     = commit && !is_fetch;

  // Address split: offset, set index, tag
  always_comb begin
    sb_eff   = (32'(set_bits) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits;
    addr_sh  = in_data.address >> block_bits;
    set_idx  = addr_sh[SET_W-1:0] & ~({SET_W{1'b1}} << sb_eff);
    tag_sh   = {1'b0, block_bits} + {4'b0, sb_eff};
    tag_calc = tag_sh[6] ? '0 : (in_data.address >> tag_sh[5:0]);
  end

  salc_ram #(
    .WIDTH(ROW_W),
    .DEPTH(DEPTH)
  ) u_set_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(set_q),
    .wr_data(row_wr),
    .rd_en  (in_acc),
    .rd_addr(set_idx),
    .rd_data(row_rd)
  );

  salc_set_update #(
    .MAX_WAYS(MAX_WAYS)
  ) u_update (
    .row_in   (row_rd),
    .fresh    (fresh_q),
    .tag      (tag_q),
    .ways_used(ways_used),
    .row_out  (row_wr),
    .res      (res)
  );

  // Result of the access in the update cycle
  always_comb begin
    hits_now = 2'd0;
    if (!is_fetch) begin
      hits_now = {1'b0, res.hit} + {1'b0, (op_q == OP_MODIFY)};
    end
    out_next.hits           = hits_now;
    out_next.missed         = !is_fetch && !res.hit;
    out_next.evicted        = !is_fetch && !res.hit && res.evict;
    out_next.hit_total      = sat_add(hit_total, hits_now);
    out_next.miss_total     = sat_add(miss_total, {1'b0, out_next.missed});
    out_next.eviction_total = sat_add(eviction_total, {1'b0, out_next.evicted});
  end

  // Control state, config and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      out_valid      <= 1'b0;
      set_bits       <= 3'd0;
      ways_used      <= 4'd1;
      block_bits     <= 6'd0;
      hit_total      <= '0;
      miss_total     <= '0;
      eviction_total <= '0;
      row_written    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SET_BITS:   set_bits   <= cfg_data[2:0];
          CFG_WAYS_USED:  ways_used  <= cfg_data[3:0];
          CFG_BLOCK_BITS: block_bits <= cfg_data;
          default: ;
        endcase
      end
      // Output register valid flag
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (commit) begin
            state          <= ST_IDLE;
            hit_total      <= out_next.hit_total;
            miss_total     <= out_next.miss_total;
            eviction_total <= out_next.eviction_total;
            if (wr_en) begin
              row_written[set_q] <= 1'b1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item payload and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_q    <= in_data.op;
      tag_q   <= tag_calc;
      set_q   <= set_idx;
      fresh_q <= !row_written[set_idx];
    end
    if (commit) begin
      out_data <= out_next;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/salc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [ADDR_W-1:0]         wr_addr,
  input  wire logic [WIDTH-1:0]          wr_data,
  input  wire logic                      rd_en,
  input  wire logic [ADDR_W-1:0]         rd_addr,
  output logic      [WIDTH-1:0]          rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/salc_set_update.sv =====
// Tag match, victim choice and LRU rank update for one set row.
`default_nettype none
module salc_set_update
  import salc_pkg::*;
#(
  parameter int MAX_WAYS = MAX_WAYS_DEF,
  localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  localparam int WAY_W  = 1 + TAG_W + RANK_W,
  localparam int ROW_W  = MAX_WAYS * WAY_W
) (
  input  wire logic [ROW_W-1:0] row_in,
  input  wire logic             fresh,
  input  wire logic [TAG_W-1:0] tag,
  input  wire logic [3:0]       ways_used,
  output logic      [ROW_W-1:0] row_out,
  output acc_res_t              res
);
  logic              valid   [MAX_WAYS];
  logic [TAG_W-1:0]  tags    [MAX_WAYS];
  logic [RANK_W-1:0] rank    [MAX_WAYS];
  logic [MAX_WAYS-1:0] in_use, hit_vec, free_vec;
  logic [4:0]        wu, wu_eff;
  logic [RANK_W-1:0] hit_way, free_way, lru_way, pick, pick_rank;
  logic              any_hit, any_free;

  // Clamp associativity to 1..MAX_WAYS
  always_comb begin
    wu = {1'b0, ways_used};
    if (wu == 5'd0) begin
      wu_eff = 5'd1;
    end else if (wu > 5'(MAX_WAYS)) begin
      wu_eff = 5'(MAX_WAYS);
    end else begin
      wu_eff = wu;
    end
  end

  // Unpack the row; a never-written row reads as the reset state
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (fresh) begin
        valid[w] = 1'b0;
        tags[w]  = '0;
        rank[w]  = RANK_W'(w);
      end else begin
        {valid[w], tags[w], rank[w]} = row_in[w*WAY_W +: WAY_W];
      end
      in_use[w]   = 5'(w) < wu_eff;
      hit_vec[w]  = in_use[w] && valid[w] && (tags[w] == tag);
      free_vec[w] = in_use[w] && !valid[w];
    end
  end

  // Lowest hitting way and lowest free way
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = RANK_W'(w);
      end
      if (free_vec[w]) begin
        free_way = RANK_W'(w);
      end
    end
    any_hit  = |hit_vec;
    any_free = |free_vec;
  end

  // Least recent way among those in use
  always_comb begin
    lru_way = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rank[w] > rank[lru_way])) begin
        lru_way = RANK_W'(w);
      end
    end
  end

  assign pick      = any_hit ? hit_way : (any_free ? free_way : lru_way);
  assign pick_rank = rank[pick];
  assign res.hit   = any_hit;
  assign res.evict = !any_hit && !any_free;

  // Fill on miss, move picked way to most recent
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (RANK_W'(w) == pick) begin
        row_out[w*WAY_W +: WAY_W] = any_hit ? {valid[w], tags[w], {RANK_W{1'b0}}}
                                            : {1'b1, tag, {RANK_W{1'b0}}};
      end else if (rank[w] < pick_rank) begin
        row_out[w*WAY_W +: WAY_W] = {valid[w], tags[w], rank[w] + RANK_W'(1)};
      end else begin
        row_out[w*WAY_W +: WAY_W] = {valid[w], tags[w], rank[w]};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/salc_checker.sv =====
// Port-level checker for the cache simulator core, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module salc_checker
  import salc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);
  // One item in flight: no accept in the cycle after an accept
  `SALC_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // An eviction is always a miss, and hits never reach three
  `SALC_ASSERT_IMPL(a_result_shape, out_valid, (!out_data.evicted || out_data.missed) && (out_data.hits != 2'd3))

  // Hit and miss totals never go down
  `SALC_ASSERT_NEXT(a_totals_grow, out_valid, (out_data.hit_total >= $past(out_data.hit_total)) && (out_data.miss_total >= $past(out_data.miss_total)))

  // A stalled result holds
  `SALC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind set_assoc_lru_cache_sim_core salc_checker u_salc_checker (.*);
`default_nettype wire
